[hw/rtl/stt_pkg.sv]
`timescale 1ns / 1ps
package stt_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W = 8;
  localparam int KIND_W = 2;
  localparam int DUR_W = 31;
  localparam int PAY_W = 16;
  localparam int REM_W = 32;
  localparam int RK_W = 3;
  localparam int STEP_W = 10;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KILL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ONE_SHOT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KEEP_LONGER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_KEEP_SHORTER = 2'd3;

  localparam logic [RK_W-1:0] RK_EXPIRY = 3'd0;
  localparam logic [RK_W-1:0] RK_SET_DONE = 3'd1;
  localparam logic [RK_W-1:0] RK_SET_FAIL = 3'd2;
  localparam logic [RK_W-1:0] RK_KILLED = 3'd3;
  localparam logic [RK_W-1:0] RK_NOT_FOUND = 3'd4;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd10;

  typedef struct packed {
    logic [KEY_W-1:0] target;
    logic [KEY_W-1:0] command;
    logic periodic;
    logic [DUR_W-1:0] period;
    logic signed [REM_W-1:0] remaining;
    logic signed [PAY_W-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic eval_en;
    logic finish;
  } stt_cmd_t;

endpackage

[hw/rtl/software_timer_table_core.sv]
`timescale 1ns / 1ps
// An item is accepted in idle; the scan then reads every slot one ahead of its evaluation,
// a last state evaluates the final slot, and the finish state registers the final result.
// No new item is accepted until busy drops after finish; the scan reads one slot per cycle.
// Expiries of a tick come out during the scan, at most one per cycle, each held until the
// next expiry or the end of the scan. The receiver cannot stall: one cycle per result.
// Reset (rst, synchronous): all slots free, tick step 10, no result pending.
module software_timer_table_core #(
  parameter int TIMER_SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [stt_pkg::MODE_W-1:0] mode,
  input  logic [stt_pkg::KEY_W-1:0] target_id,
  input  logic [stt_pkg::KEY_W-1:0] command,
  input  logic [stt_pkg::KIND_W-1:0] timer_kind,
  input  logic [stt_pkg::DUR_W-1:0] duration_ms,
  input  logic signed [stt_pkg::PAY_W-1:0] payload,
  input  logic cfg_we,
  input  logic [stt_pkg::STEP_W-1:0] cfg_wdata,
  output logic result_valid,
  output logic [stt_pkg::RK_W-1:0] result_kind,
  output logic [stt_pkg::KEY_W-1:0] out_target,
  output logic [stt_pkg::KEY_W-1:0] out_command,
  output logic signed [stt_pkg::PAY_W-1:0] out_payload,
  output logic last
);
  import stt_pkg::*;

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  stt_cmd_t cmd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] eval_addr;

  stt_ctrl #(.TIMER_SLOTS(TIMER_SLOTS)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .eval_addr(eval_addr)
  );

  stt_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .eval_addr(eval_addr),
    .mode(mode),
    .target_id(target_id),
    .command(command),
    .timer_kind(timer_kind),
    .duration_ms(duration_ms),
    .payload(payload),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .result_valid(result_valid),
    .result_kind(result_kind),
    .out_target(out_target),
    .out_command(out_command),
    .out_payload(out_payload),
    .last(last)
  );

endmodule

[hw/rtl/stt_ctrl.sv]
`timescale 1ns / 1ps
module stt_ctrl #(
  parameter int TIMER_SLOTS = 8,
  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output stt_pkg::stt_cmd_t cmd,
  output logic [IW-1:0] rd_addr,
  output logic [IW-1:0] eval_addr
);
  import stt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  logic [1:0] state;
  logic [1:0] state_next;
  logic [IW-1:0] cnt;
  logic [IW-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    rd_addr = cnt;
    eval_addr = cnt - IW'(1);
    unique case (state)
      S_IDLE: begin
        cmd.load_item = start;
        if (start) begin
          state_next = S_SCAN;
          cnt_next = '0;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.eval_en = (cnt != '0);
        if (cnt == LAST_IDX) begin
          state_next = S_LAST;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end
      S_LAST: begin
        cmd.eval_en = 1'b1;
        eval_addr = cnt;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_read_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> cmd.eval_en) else $error("slot read not followed by evaluation");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !busy) else $error("busy after finish");

endmodule

[hw/rtl/stt_datapath.sv]
`timescale 1ns / 1ps
module stt_datapath #(
  parameter int TIMER_SLOTS = 8,
  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  stt_pkg::stt_cmd_t cmd,
  input  logic [IW-1:0] rd_addr,
  input  logic [IW-1:0] eval_addr,
  input  logic [stt_pkg::MODE_W-1:0] mode,
  input  logic [stt_pkg::KEY_W-1:0] target_id,
  input  logic [stt_pkg::KEY_W-1:0] command,
  input  logic [stt_pkg::KIND_W-1:0] timer_kind,
  input  logic [stt_pkg::DUR_W-1:0] duration_ms,
  input  logic signed [stt_pkg::PAY_W-1:0] payload,
  input  logic cfg_we,
  input  logic [stt_pkg::STEP_W-1:0] cfg_wdata,
  output logic result_valid,
  output logic [stt_pkg::RK_W-1:0] result_kind,
  output logic [stt_pkg::KEY_W-1:0] out_target,
  output logic [stt_pkg::KEY_W-1:0] out_command,
  output logic signed [stt_pkg::PAY_W-1:0] out_payload,
  output logic last
);
  import stt_pkg::*;

  logic [STEP_W-1:0] tick_step;
  logic [MODE_W-1:0] it_mode;
  logic [KEY_W-1:0] it_target;
  logic [KEY_W-1:0] it_command;
  logic [KIND_W-1:0] it_kind;
  logic [DUR_W-1:0] it_duration;
  logic signed [PAY_W-1:0] it_payload;

  slot_t mem [TIMER_SLOTS];
  slot_t rd_slot;
  slot_t wr_slot;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  logic [TIMER_SLOTS-1:0] active;

  logic found;
  logic pick_ok;
  logic [IW-1:0] pick;
  logic signed [REM_W-1:0] set_load;

  logic pend_valid;
  logic [KEY_W-1:0] pend_target;
  logic [KEY_W-1:0] pend_command;
  logic signed [PAY_W-1:0] pend_payload;

  logic slot_on;
  logic key_hit;
  logic [REM_W:0] diff;
  logic under;
  logic [REM_W-1:0] dec;
  logic expire;
  logic [REM_W+1:0] reload_sum;
  logic [REM_W-1:0] reload;
  logic [REM_W-1:0] new_rem;
  logic signed [REM_W-1:0] dur_s;
  logic keep;
  logic tick_eval;
  logic set_commit;
  logic exp_valid;
  logic fin_valid;

  assign slot_on = active[eval_addr];
  assign key_hit = slot_on && (rd_slot.target == it_target) && (rd_slot.command == it_command);
  assign diff = {rd_slot.remaining[REM_W-1], rd_slot.remaining}
              - {{(REM_W + 1 - STEP_W){1'b0}}, tick_step};
  assign under = diff[REM_W] & ~diff[REM_W-1];
  assign dec = under ? {1'b1, {(REM_W-1){1'b0}}} : diff[REM_W-1:0];
  assign expire = dec[REM_W-1] | (dec == '0);
  assign reload_sum = {diff[REM_W], diff} + {{(REM_W + 2 - DUR_W){1'b0}}, rd_slot.period};
  assign reload = under ? {1'b1, rd_slot.period} : reload_sum[REM_W-1:0];
  assign new_rem = (expire && rd_slot.periodic) ? reload : dec;
  assign dur_s = signed'({1'b0, it_duration});
  assign keep = ((it_kind == KIND_KEEP_LONGER) && (rd_slot.remaining > dur_s))
             || ((it_kind == KIND_KEEP_SHORTER) && (rd_slot.remaining < dur_s));
  assign tick_eval = cmd.eval_en && (it_mode == MODE_TICK) && slot_on;
  assign set_commit = cmd.finish && (it_mode == MODE_SET) && (found || pick_ok);
  assign exp_valid = tick_eval && expire && pend_valid;
  assign fin_valid = cmd.finish && (((it_mode == MODE_TICK) && pend_valid)
                                    || (it_mode == MODE_SET) || (it_mode == MODE_KILL));

  always_comb begin
    wr_en = 1'b0;
    wr_addr = eval_addr;
    wr_slot = rd_slot;
    if (tick_eval) begin
      wr_en = 1'b1;
      wr_slot.remaining = new_rem;
    end else if (set_commit) begin
      wr_en = 1'b1;
      wr_addr = pick;
      wr_slot.target = it_target;
      wr_slot.command = it_command;
      wr_slot.periodic = (it_kind == KIND_PERIODIC);
      wr_slot.period = set_load[REM_W-1] ? '0 : set_load[DUR_W-1:0];
      wr_slot.remaining = set_load;
      wr_slot.payload = it_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_slot;
    end
    if (cmd.rd_en) begin
      rd_slot <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
      active <= '0;
      found <= 1'b0;
      pick_ok <= 1'b0;
      pend_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= exp_valid || fin_valid;
      if (cfg_we) begin
        tick_step <= cfg_wdata;
      end
      if (cmd.load_item) begin
        found <= 1'b0;
        pick_ok <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (cmd.eval_en) begin
        case (it_mode)
          MODE_TICK: begin
            if (slot_on && expire) begin
              pend_valid <= 1'b1;
              if (!rd_slot.periodic) begin
                active[eval_addr] <= 1'b0;
              end
            end
          end
          MODE_SET: begin
            if (!found && (key_hit || !slot_on)) begin
              found <= key_hit;
              pick_ok <= 1'b1;
            end
          end
          MODE_KILL: begin
            if (!found && key_hit) begin
              found <= 1'b1;
              active[eval_addr] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        case (it_mode)
          MODE_TICK: begin
            pend_valid <= 1'b0;
          end
          MODE_SET: begin
            if (found || pick_ok) begin
              active[pick] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_mode <= mode;
      it_target <= target_id;
      it_command <= command;
      it_kind <= timer_kind;
      it_duration <= duration_ms;
      it_payload <= payload;
    end
    if (cmd.eval_en && (it_mode == MODE_SET) && !found && (key_hit || !slot_on)) begin
      pick <= eval_addr;
      set_load <= (key_hit && keep) ? rd_slot.remaining : dur_s;
    end
    if (tick_eval && expire) begin
      pend_target <= rd_slot.target;
      pend_command <= rd_slot.command;
      pend_payload <= rd_slot.payload;
      result_kind <= RK_EXPIRY;
      out_target <= pend_target;
      out_command <= pend_command;
      out_payload <= pend_payload;
      last <= 1'b0;
    end
    if (cmd.finish) begin
      last <= 1'b1;
      if (it_mode == MODE_TICK) begin
        result_kind <= RK_EXPIRY;
        out_target <= pend_target;
        out_command <= pend_command;
        out_payload <= pend_payload;
      end else begin
        out_target <= it_target;
        out_command <= it_command;
        out_payload <= '0;
        case (it_mode)
          MODE_SET: begin
            result_kind <= (found || pick_ok) ? RK_SET_DONE : RK_SET_FAIL;
          end
          MODE_KILL: begin
            result_kind <= found ? RK_KILLED : RK_NOT_FOUND;
          end
          default: begin
            result_kind <= RK_EXPIRY;
          end
        endcase
      end
    end
  end

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid) else $error("result after final item result");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_kind != RK_EXPIRY)) |-> last) else $error("status not final");
  a_pend_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !pend_valid) else $error("pending expiry left after finish");

endmodule
